// ===== rtl/stb_pkg.sv =====
// shared constants, codes, command/status structs and address helper
// for the square tracing boundary block; no dependencies
package stb_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int STEP_LIMIT = 16384;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int FUNC_W = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 1;
    localparam int POS_W  = CFG_W + 1;
    localparam int STEP_W = $clog2(STEP_LIMIT + 1);

    localparam logic [PIX_W-1:0] OBJ_VALUE = 8'd255;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam logic [CFG_W-1:0] ROWS_CAP  = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_CAP  = CFG_W'(MAX_COLS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_TRACE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [IDX_W-1:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg;

    // turning right adds one, turning left subtracts one
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_READ  = 2'd1,
        RES_TRACE = 2'd2
    } t_res_sel;

    typedef enum logic [3:0] {
        S_INIT_CLR  = 4'd0,
        S_IDLE      = 4'd1,
        S_READ_WAIT = 4'd2,
        S_CLEAR     = 4'd3,
        S_SCAN_RD   = 4'd4,
        S_SCAN_CHK  = 4'd5,
        S_WALK_CHK  = 4'd6,
        S_WALK_EVAL = 4'd7,
        S_DONE      = 4'd8
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     clr_step;
        logic     scan_rd;
        logic     scan_adv;
        logic     walk_init;
        logic     walk_rd;
        logic     walk_eval;
        logic     set_limit;
        logic     load_out;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic img_empty;
        logic scan_hit;
        logic scan_last;
        logic walk_home;
        logic walk_limit;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

endpackage

// ===== rtl/square_tracing_boundary_top.sv =====
// top level of the square tracing boundary block
// depends on stb_pkg, stb_ctrl, stb_dp (and stb_ram through stb_dp)
//
// usage
//   input channel i_valid/o_stall carries one beat per command: func 0 writes
//   a pixel (object when value is 255), func 1 traces the object boundary,
//   func 2 reads one boundary pixel back as 0 or 255, func 3 does nothing
//   output channel o_valid/i_stall returns exactly one result beat per command
//   image size comes from the cfg write port (rows, cols), written while idle
// sequencing, one command in flight at a time
//   write / no-op: result registered on accept, next beat taken
//     in the cycle the result leaves, so one beat per cycle when not stalled
//   read: boundary map read registered on accept, result loaded in S_READ_WAIT
//   trace: boundary map cleared, pixels scanned up to the start pixel (read,
//     then check), walk steps each read the object map, then turn and move;
//     the walk stops after 16383 steps at most
// reset
//   synchronous active-low; after reset the whole boundary map is swept to zero
//   while o_stall stays high; cfg writes are taken throughout
// stall
//   a held result blocks new beats; a stalled result does not change
module square_tracing_boundary_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [stb_pkg::FUNC_W-1:0] i_func,
    input  logic [stb_pkg::ROW_W-1:0]  i_row,
    input  logic [stb_pkg::COL_W-1:0]  i_col,
    input  logic [stb_pkg::PIX_W-1:0]  i_pixel_value,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [stb_pkg::PIX_W-1:0]  o_boundary_pixel,
    output logic                       o_start_found,
    output logic                       o_limit_hit,
    // configuration writes
    input  logic                       i_cfg_wr_en,
    input  logic [stb_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [stb_pkg::CFG_W-1:0]  i_cfg_data
);

    // command and status between sequencer and datapath
    stb_pkg::t_cmd  cmd;
    stb_pkg::t_stat stat;

    stb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // maps, scan and walk registers, result register
    stb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_func           (i_func),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel_value    (i_pixel_value),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_boundary_pixel (o_boundary_pixel),
        .o_start_found    (o_start_found),
        .o_limit_hit      (o_limit_hit)
    );

endmodule

// ===== rtl/stb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module stb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/stb_ctrl.sv =====
// controller fsm: handshakes, output valid and datapath sequencing
// depends on stb_pkg
module stb_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [stb_pkg::FUNC_W-1:0] i_func,
    output logic                      o_valid,
    input  logic                      i_stall,
    input  stb_pkg::t_stat            i_stat,
    output stb_pkg::t_cmd             o_cmd
);

    stb_pkg::t_state r_state;
    stb_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;
    logic            in_acc;
    stb_pkg::t_func  func;
    stb_pkg::t_cmd   cmd;

    assign func     = stb_pkg::t_func'(i_func);
    assign out_free = !r_out_valid || !i_stall;
    assign in_acc   = i_valid && (r_state == stb_pkg::S_IDLE) && out_free;
    assign o_stall  = !((r_state == stb_pkg::S_IDLE) && out_free);
    assign o_valid  = r_out_valid;
    assign o_cmd    = cmd;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stb_pkg::S_INIT_CLR: begin
                if (i_stat.clr_last) n_state = stb_pkg::S_IDLE;
            end
            stb_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (func)
                        stb_pkg::FUNC_READ:  n_state = stb_pkg::S_READ_WAIT;
                        stb_pkg::FUNC_TRACE: n_state = stb_pkg::S_CLEAR;
                        default:             n_state = stb_pkg::S_IDLE;
                    endcase
                end
            end
            stb_pkg::S_READ_WAIT: n_state = stb_pkg::S_IDLE;
            stb_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = i_stat.img_empty ? stb_pkg::S_DONE : stb_pkg::S_SCAN_RD;
                end
            end
            stb_pkg::S_SCAN_RD: n_state = stb_pkg::S_SCAN_CHK;
            stb_pkg::S_SCAN_CHK: begin
                if (i_stat.scan_hit) begin
                    n_state = stb_pkg::S_WALK_CHK;
                end else if (i_stat.scan_last) begin
                    n_state = stb_pkg::S_DONE;
                end else begin
                    n_state = stb_pkg::S_SCAN_RD;
                end
            end
            stb_pkg::S_WALK_CHK: begin
                if (i_stat.walk_home || i_stat.walk_limit) begin
                    n_state = stb_pkg::S_DONE;
                end else begin
                    n_state = stb_pkg::S_WALK_EVAL;
                end
            end
            stb_pkg::S_WALK_EVAL: n_state = stb_pkg::S_WALK_CHK;
            stb_pkg::S_DONE:      n_state = stb_pkg::S_IDLE;
            default:              n_state = stb_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        cmd.res_sel = stb_pkg::RES_ZERO;
        case (r_state)
            stb_pkg::S_INIT_CLR: cmd.clr_step = 1'b1;
            stb_pkg::S_IDLE: begin
                cmd.accept = in_acc;
                if (in_acc && (func == stb_pkg::FUNC_WRITE || func == stb_pkg::FUNC_NONE)) begin
                    cmd.load_out = 1'b1;
                end
            end
            stb_pkg::S_READ_WAIT: begin
                cmd.load_out = 1'b1;
                cmd.res_sel  = stb_pkg::RES_READ;
            end
            stb_pkg::S_CLEAR:   cmd.clr_step = 1'b1;
            stb_pkg::S_SCAN_RD: cmd.scan_rd  = 1'b1;
            stb_pkg::S_SCAN_CHK: begin
                if (i_stat.scan_hit) begin
                    cmd.walk_init = 1'b1;
                end else if (!i_stat.scan_last) begin
                    cmd.scan_adv = 1'b1;
                end
            end
            stb_pkg::S_WALK_CHK: begin
                if (!i_stat.walk_home) begin
                    if (i_stat.walk_limit) begin
                        cmd.set_limit = 1'b1;
                    end else begin
                        cmd.walk_rd = 1'b1;
                    end
                end
            end
            stb_pkg::S_WALK_EVAL: cmd.walk_eval = 1'b1;
            stb_pkg::S_DONE: begin
                cmd.load_out = 1'b1;
                cmd.res_sel  = stb_pkg::RES_TRACE;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stb_pkg::S_INIT_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // an accepted item never finds an untaken result in the way
    a_acc_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> out_free)
        else $error("input beat accepted while output register is held");

    // a result is only loaded when the previous one is gone or leaving
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> out_free)
        else $error("result overwrites an untaken result");

    // one writer of the boundary map at a time
    a_bnd_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.walk_init, cmd.walk_eval}))
        else $error("boundary map write collision");

    // every walk object read is followed by its evaluation
    a_eval_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_rd |=> cmd.walk_eval)
        else $error("walk read not followed by evaluation");

endmodule

// ===== rtl/stb_dp.sv =====
// datapath: config registers, object and boundary maps, scan and walk
// registers, result register; depends on stb_pkg and stb_ram
module stb_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [stb_pkg::FUNC_W-1:0] i_func,
    input  logic [stb_pkg::ROW_W-1:0]  i_row,
    input  logic [stb_pkg::COL_W-1:0]  i_col,
    input  logic [stb_pkg::PIX_W-1:0]  i_pixel_value,
    input  logic                       i_cfg_wr_en,
    input  logic [stb_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [stb_pkg::CFG_W-1:0]  i_cfg_data,
    input  stb_pkg::t_cmd              i_cmd,
    output stb_pkg::t_stat             o_stat,
    output logic [stb_pkg::PIX_W-1:0]  o_boundary_pixel,
    output logic                       o_start_found,
    output logic                       o_limit_hit
);

    localparam int AW = stb_pkg::ADDR_W;
    localparam int PW = stb_pkg::POS_W;

    logic [stb_pkg::CFG_W-1:0] r_rows;
    logic [stb_pkg::CFG_W-1:0] r_cols;
    logic [stb_pkg::CFG_W-1:0] eff_rows;
    logic [stb_pkg::CFG_W-1:0] eff_cols;

    logic [AW-1:0]             r_clr_cnt;
    logic [stb_pkg::ROW_W-1:0] r_scan_row;
    logic [stb_pkg::COL_W-1:0] r_scan_col;
    logic                      scan_row_end;
    logic                      scan_col_end;

    logic signed [PW-1:0]      r_sr;
    logic signed [PW-1:0]      r_sc;
    logic signed [PW-1:0]      r_nr;
    logic signed [PW-1:0]      r_nc;
    logic signed [PW-1:0]      n_nr;
    logic signed [PW-1:0]      n_nc;
    stb_pkg::t_dir             r_dir;
    stb_pkg::t_dir             n_dir;
    logic [stb_pkg::STEP_W-1:0] r_steps;
    logic                      walk_inside;
    logic                      walk_obj;

    logic                      r_found;
    logic                      r_limit;
    logic                      r_rd_inside;
    logic                      in_inside;

    logic                      obj_we;
    logic [AW-1:0]             obj_waddr;
    logic                      obj_wdata;
    logic                      obj_re;
    logic [AW-1:0]             obj_raddr;
    logic                      obj_rdata;

    logic                      bnd_we;
    logic [AW-1:0]             bnd_waddr;
    logic                      bnd_wdata;
    logic                      bnd_rdata;
    logic [AW-1:0]             walk_addr;

    logic [stb_pkg::PIX_W-1:0] r_boundary_pixel;
    logic                      r_start_found;
    logic                      r_limit_hit;

    function automatic logic signed [PW-1:0] dir_dr(input stb_pkg::t_dir d);
        case (d)
            stb_pkg::DIR_UP:   dir_dr = -PW'(1);
            stb_pkg::DIR_DOWN: dir_dr = PW'(1);
            default:           dir_dr = '0;
        endcase
    endfunction

    function automatic logic signed [PW-1:0] dir_dc(input stb_pkg::t_dir d);
        case (d)
            stb_pkg::DIR_RIGHT: dir_dc = PW'(1);
            stb_pkg::DIR_LEFT:  dir_dc = -PW'(1);
            default:            dir_dc = '0;
        endcase
    endfunction

    // registers above the maximum act as the maximum
    assign eff_rows = (r_rows > stb_pkg::ROWS_CAP) ? stb_pkg::ROWS_CAP : r_rows;
    assign eff_cols = (r_cols > stb_pkg::COLS_CAP) ? stb_pkg::COLS_CAP : r_cols;

    assign in_inside = (stb_pkg::CFG_W'(i_row) < eff_rows) &&
                       (stb_pkg::CFG_W'(i_col) < eff_cols);

    assign scan_row_end = (stb_pkg::CFG_W'(r_scan_row) == eff_rows - stb_pkg::CFG_W'(1));
    assign scan_col_end = (stb_pkg::CFG_W'(r_scan_col) == eff_cols - stb_pkg::CFG_W'(1));

    assign walk_inside = (r_nr >= 0) && (r_nr < $signed(PW'(eff_rows))) &&
                         (r_nc >= 0) && (r_nc < $signed(PW'(eff_cols)));
    assign walk_obj    = walk_inside && obj_rdata;
    assign walk_addr   = stb_pkg::cell_addr(r_nr[stb_pkg::ROW_W-1:0],
                                            r_nc[stb_pkg::COL_W-1:0]);

    // right turn on object, left turn on background
    always_comb begin
        n_dir = walk_obj ? stb_pkg::t_dir'(r_dir + 2'd1) : stb_pkg::t_dir'(r_dir - 2'd1);
        n_nr  = r_nr + dir_dr(n_dir);
        n_nc  = r_nc + dir_dc(n_dir);
    end

    // object map ports
    assign obj_we    = i_cmd.accept && (stb_pkg::t_func'(i_func) == stb_pkg::FUNC_WRITE) &&
                       in_inside;
    assign obj_waddr = stb_pkg::cell_addr(i_row, i_col);
    assign obj_wdata = (i_pixel_value == stb_pkg::OBJ_VALUE);
    assign obj_re    = i_cmd.scan_rd || i_cmd.walk_rd;
    assign obj_raddr = i_cmd.scan_rd ? stb_pkg::cell_addr(r_scan_row, r_scan_col) : walk_addr;

    // boundary map ports: clearing sweep, start mark, walk marks
    always_comb begin
        bnd_we    = 1'b0;
        bnd_waddr = r_clr_cnt;
        bnd_wdata = 1'b0;
        if (i_cmd.clr_step) begin
            bnd_we = 1'b1;
        end else if (i_cmd.walk_init) begin
            bnd_we    = 1'b1;
            bnd_waddr = stb_pkg::cell_addr(r_scan_row, r_scan_col);
            bnd_wdata = 1'b1;
        end else if (i_cmd.walk_eval && walk_obj) begin
            bnd_we    = 1'b1;
            bnd_waddr = walk_addr;
            bnd_wdata = 1'b1;
        end
    end

    stb_ram #(.WIDTH(1), .DEPTH(stb_pkg::DEPTH)) u_obj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (obj_we),
        .i_wr_addr (obj_waddr),
        .i_wr_data (obj_wdata),
        .i_rd_en   (obj_re),
        .i_rd_addr (obj_raddr),
        .o_rd_data (obj_rdata)
    );

    stb_ram #(.WIDTH(1), .DEPTH(stb_pkg::DEPTH)) u_bnd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bnd_we),
        .i_wr_addr (bnd_waddr),
        .i_wr_data (bnd_wdata),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (stb_pkg::cell_addr(i_row, i_col)),
        .o_rd_data (bnd_rdata)
    );

    assign o_stat.clr_last   = (r_clr_cnt == AW'(stb_pkg::DEPTH - 1));
    assign o_stat.img_empty  = (eff_rows == '0) || (eff_cols == '0);
    assign o_stat.scan_hit   = obj_rdata;
    assign o_stat.scan_last  = scan_row_end && scan_col_end;
    assign o_stat.walk_home  = (r_nr == r_sr) && (r_nc == r_sc);
    assign o_stat.walk_limit = (r_steps >= stb_pkg::STEP_W'(stb_pkg::STEP_LIMIT));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= stb_pkg::CFG_RESET;
            r_cols    <= stb_pkg::CFG_RESET;
            r_clr_cnt <= '0;
            r_steps   <= '0;
            r_found   <= 1'b0;
            r_limit   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (stb_pkg::t_reg'(i_cfg_index))
                    stb_pkg::REG_ROWS: r_rows <= i_cfg_data;
                    stb_pkg::REG_COLS: r_cols <= i_cfg_data;
                    default: r_rows <= r_rows;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= o_stat.clr_last ? '0 : r_clr_cnt + AW'(1);
            end
            if (i_cmd.accept && (stb_pkg::t_func'(i_func) == stb_pkg::FUNC_TRACE)) begin
                r_found <= 1'b0;
                r_limit <= 1'b0;
            end
            if (i_cmd.walk_init) begin
                r_found <= 1'b1;
                r_steps <= stb_pkg::STEP_W'(1);
            end
            if (i_cmd.walk_eval) begin
                r_steps <= r_steps + stb_pkg::STEP_W'(1);
            end
            if (i_cmd.set_limit) begin
                r_limit <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_scan_row  <= '0;
            r_scan_col  <= '0;
            r_rd_inside <= in_inside;
        end
        if (i_cmd.scan_adv) begin
            if (scan_col_end) begin
                r_scan_col <= '0;
                r_scan_row <= r_scan_row + stb_pkg::ROW_W'(1);
            end else begin
                r_scan_col <= r_scan_col + stb_pkg::COL_W'(1);
            end
        end
        if (i_cmd.walk_init) begin
            r_sr  <= PW'(r_scan_row);
            r_sc  <= PW'(r_scan_col);
            r_nr  <= PW'(r_scan_row);
            r_nc  <= PW'(r_scan_col) - PW'(1);
            r_dir <= stb_pkg::DIR_LEFT;
        end
        if (i_cmd.walk_eval) begin
            r_nr  <= n_nr;
            r_nc  <= n_nc;
            r_dir <= n_dir;
        end
        if (i_cmd.load_out) begin
            case (i_cmd.res_sel)
                stb_pkg::RES_READ: begin
                    r_boundary_pixel <= (r_rd_inside && bnd_rdata) ? stb_pkg::OBJ_VALUE : '0;
                    r_start_found    <= 1'b0;
                    r_limit_hit      <= 1'b0;
                end
                stb_pkg::RES_TRACE: begin
                    r_boundary_pixel <= '0;
                    r_start_found    <= r_found;
                    r_limit_hit      <= r_limit;
                end
                default: begin
                    r_boundary_pixel <= '0;
                    r_start_found    <= 1'b0;
                    r_limit_hit      <= 1'b0;
                end
            endcase
        end
    end

    assign o_boundary_pixel = r_boundary_pixel;
    assign o_start_found    = r_start_found;
    assign o_limit_hit      = r_limit_hit;

endmodule
